// File: src/sdct_pkg.sv
// ----------------------------------------------------------------------------
// sdct_pkg
// Types and constants shared by the sensor detection counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package sdct_pkg;

  localparam int unsigned CountW = 10;
  localparam int unsigned AlarmW = 16;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned SlotW  = 4;

  localparam logic [CountW-1:0] HalvingLimitRst = 10'd1000;

  typedef enum logic [1:0] {
    OP_ADJUST = 2'd0,
    OP_ALARM  = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_HIT  = 2'd0,
    STAT_NEW  = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic [AlarmW-1:0] alarm;
    logic [CountW-1:0] total;
    logic [CountW-1:0] correct;
  } counts_t;

  typedef struct packed {
    logic hit;
    logic free;
  } lookup_t;

endpackage : sdct_pkg

`default_nettype wire

// File: src/sdct_lookup.sv
// ----------------------------------------------------------------------------
// sdct_lookup
// Key registers and valid bits; parallel key match and lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module sdct_lookup
  import sdct_pkg::*;
#(
  parameter int unsigned Entries = 16,
  parameter int unsigned IdxW    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic            alloc_i,
  output lookup_t              res_o,
  output logic      [IdxW-1:0] idx_o
);

  logic [KeyW-1:0]    key_q [Entries];
  logic [Entries-1:0] valid_q;
  logic               hit;
  logic               free;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    free_idx;

  // lowest index wins: scan downward so the last assignment is the lowest
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == key_i)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign res_o.hit  = hit;
  assign res_o.free = free;
  assign idx_o      = hit ? hit_idx : free_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (alloc_i) begin
      valid_q[idx_o] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      key_q[idx_o] <= key_i;
    end
  end

endmodule : sdct_lookup

`default_nettype wire

// File: src/sdct_count_mem.sv
// ----------------------------------------------------------------------------
// sdct_count_mem
// Counter memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdct_count_mem
  import sdct_pkg::*;
#(
  parameter int unsigned Entries = 16,
  parameter int unsigned IdxW    = 4
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire counts_t         wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output counts_t              rdata_o
);

  counts_t mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : sdct_count_mem

`default_nettype wire

// File: src/sdct_update.sv
// ----------------------------------------------------------------------------
// sdct_update
// Counter update: detection count with halving and clamp, alarm count.
// ----------------------------------------------------------------------------
`default_nettype none

module sdct_update
  import sdct_pkg::*;
(
  input  wire op_e               op_i,
  input  wire logic              in_alarm_i,
  input  wire logic [CountW-1:0] limit_i,
  input  wire counts_t           cur_i,
  output counts_t                nxt_o
);

  logic [CountW-1:0] tot;
  logic [CountW-1:0] cor;
  logic [CountW-1:0] cor_inc;

  always_comb begin
    tot = cur_i.total + CountW'(1);
    cor = cur_i.correct;
    if (tot >= limit_i) begin
      tot = tot >> 1;
      cor = cor >> 1;
    end
    cor_inc = cor + CountW'(1);
    if (in_alarm_i) begin
      cor = (cor_inc > tot) ? tot : cor_inc;
    end
  end

  always_comb begin
    nxt_o = cur_i;
    case (op_i)
      OP_ADJUST: begin
        nxt_o.total   = tot;
        nxt_o.correct = cor;
      end
      OP_ALARM: nxt_o.alarm = cur_i.alarm + AlarmW'(1);
      default: nxt_o = cur_i;
    endcase
  end

endmodule : sdct_update

`default_nettype wire

// File: src/sensor_detection_counter_table_top.sv
// ----------------------------------------------------------------------------
// sensor_detection_counter_table_top
// Per-sensor detection counter table with allocate on miss.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (operation, sensor key, in_alarm) transfers at a
//   clock edge with start_i high and busy_o low. One result per item appears
//   for exactly one cycle with done_o high, in the update state. Each item
//   takes a lookup step against the key registers that also reads the counter
//   memory, then an update step that writes the counters back and presents
//   the result. busy_o is high only in the lookup cycle, so the next item can
//   transfer during the result cycle. The user must write halving_limit with
//   halving_limit_we_i only while no item is in flight; the block does not
//   enforce this. Reset clears all valid bits and sets halving_limit to 1000;
//   the counter memory needs no clearing since allocation zeroes the counts.
//   The receiver cannot stall: results must be taken when done_o is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_detection_counter_table_top
  import sdct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              halving_limit_we_i,
  input  wire logic [CountW-1:0] halving_limit_i,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [KeyW-1:0]   sensor_key_i,
  input  wire logic              in_alarm_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [SlotW-1:0]       slot_o,
  output logic [CountW-1:0]      correct_count_o,
  output logic [CountW-1:0]      total_count_o,
  output logic [AlarmW-1:0]      alarm_count_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  state_e            state_q, state_d;
  logic [CountW-1:0] limit_q;
  op_e               op_q;
  logic [KeyW-1:0]   key_q;
  logic              in_alarm_q;
  status_e           status_q, status_d;
  logic [IdxW-1:0]   slot_q;

  lookup_t           lk;
  logic [IdxW-1:0]   lk_idx;
  logic              alloc;
  logic              accept;
  counts_t           rdata;
  counts_t           cur;
  counts_t           nxt;
  logic              mem_we;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HalvingLimitRst;
    end else if (halving_limit_we_i) begin
      limit_q <= halving_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(operation_i);
      key_q      <= sensor_key_i;
      in_alarm_q <= in_alarm_i;
    end
    if (state_q == S_LOOKUP) begin
      status_q <= status_d;
      slot_q   <= lk_idx;
    end
  end

  always_comb begin
    state_d  = state_q;
    busy_o   = 1'b0;
    done_o   = 1'b0;
    alloc    = 1'b0;
    status_d = STAT_NONE;
    if (lk.hit) begin
      status_d = STAT_HIT;
    end else if (lk.free && (op_q == OP_ADJUST || op_q == OP_ALARM)) begin
      status_d = STAT_NEW;
    end
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        busy_o  = 1'b1;
        alloc   = (status_d == STAT_NEW);
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        done_o  = 1'b1;
        state_d = start_i ? S_LOOKUP : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  sdct_lookup #(
    .Entries (TABLE_ENTRIES),
    .IdxW    (IdxW)
  ) u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (key_q),
    .alloc_i (alloc),
    .res_o   (lk),
    .idx_o   (lk_idx)
  );

  sdct_count_mem #(
    .Entries (TABLE_ENTRIES),
    .IdxW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (nxt),
    .raddr_i (lk_idx),
    .rdata_o (rdata)
  );

  assign cur    = (status_q == STAT_NEW) ? '0 : rdata;
  assign mem_we = (state_q == S_UPDATE) && (status_q != STAT_NONE);

  sdct_update u_update (
    .op_i       (op_q),
    .in_alarm_i (in_alarm_q),
    .limit_i    (limit_q),
    .cur_i      (cur),
    .nxt_o      (nxt)
  );

  assign status_o        = status_q;
  assign slot_o          = (status_q == STAT_NONE) ? '0 : SlotW'(slot_q);
  assign correct_count_o = (status_q == STAT_NONE) ? '0 : nxt.correct;
  assign total_count_o   = (status_q == STAT_NONE) ? '0 : nxt.total;
  assign alarm_count_o   = (status_q == STAT_NONE) ? '0 : nxt.alarm;

  a_accept_to_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted transfer did not enter lookup");

  a_done_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STAT_NONE |-> slot_o == '0 && total_count_o == '0
      && correct_count_o == '0 && alarm_count_o == '0)
    else $error("no-entry result carries nonzero fields");

  a_correct_le_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> correct_count_o <= total_count_o)
    else $error("correct count exceeds total count");

endmodule : sensor_detection_counter_table_top

`default_nettype wire
